### hw/rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    // Default sizing for the top-level parameters
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Capacity register: fixed width and reset value
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    // Request kinds carried on the slave tuser
    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_GET    = 2'd1,
        KIND_EXISTS = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    // Result flags from the store to the output stage
    typedef struct packed {
        logic evicted;
        logic hit;
    } t_flags;

endpackage

### hw/rtl/lkvc_store.sv
// Entry store: key CAM, value array, recency ranks and their update.
module lkvc_store
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  t_kind                  i_kind,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [VALUE_WIDTH-1:0] i_write_value,
    input  logic [VALUE_WIDTH-1:0] i_default_value,
    input  logic [CAP_W-1:0]       i_capacity,
    output t_flags                 o_flags,
    output logic [VALUE_WIDTH-1:0] o_read_value
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [KEY_WIDTH-1:0]   r_key   [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] r_value [MAX_ENTRIES];
    logic [IDX_W-1:0]       r_rank  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] bump;
    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       victim_idx;
    logic [IDX_W-1:0]       tgt;
    logic [IDX_W-1:0]       tgt_rank;
    logic [IDX_W-1:0]       oldest_rank;
    logic [CMP_W-1:0]       cap_raw;
    logic [CMP_W-1:0]       cap_eff;
    logic                   full;
    logic                   do_set;
    logic                   do_promote;
    logic                   do_insert;

    // Compare the key against every entry and locate hit, free and victim slots
    always_comb begin
        oldest_rank = IDX_W'(r_count - CNT_W'(1));
        any_hit     = 1'b0;
        hit_idx     = '0;
        free_idx    = '0;
        victim_idx  = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_key[i] == i_key);
            if (match[i]) begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        // Ranks of valid entries form a permutation, so the oldest has rank count-1
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_valid[i] && (r_rank[i] == oldest_rank)) begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    // Clamp capacity into one to MAX_ENTRIES and check for a full store
    always_comb begin
        cap_raw = CMP_W'(i_capacity);
        if (cap_raw == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_raw > CMP_W'(MAX_ENTRIES)) begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end else begin
            cap_eff = cap_raw;
        end
        full = CMP_W'(r_count) >= cap_eff;
    end

    // Pick the slot to touch and the entries that age by one
    always_comb begin
        do_set     = i_go && (i_kind == KIND_SET);
        do_promote = i_go && any_hit && ((i_kind == KIND_SET) || (i_kind == KIND_GET));
        do_insert  = do_set && !any_hit;
        if (any_hit) begin
            tgt = hit_idx;
        end else if (full) begin
            tgt = victim_idx;
        end else begin
            tgt = free_idx;
        end
        tgt_rank = r_rank[tgt];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            bump[i] = r_valid[i] && (IDX_W'(i) != tgt) &&
                      (!any_hit || (r_rank[i] < tgt_rank));
        end
    end

    // Form the result for this request
    always_comb begin
        o_flags.hit     = any_hit && (i_kind != KIND_NOP);
        o_flags.evicted = (i_kind == KIND_SET) && !any_hit && full;
        if (i_kind == KIND_GET) begin
            o_read_value = any_hit ? r_value[hit_idx] : i_default_value;
        end else begin
            o_read_value = '0;
        end
    end

    // Update valid bits, ranks and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (do_promote || do_insert) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (IDX_W'(i) == tgt) begin
                        r_rank[i] <= '0;
                    end else if (bump[i]) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
            end
            if (do_insert) begin
                r_valid[tgt] <= 1'b1;
                if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Write key and value on a set
    always_ff @(posedge i_clk) begin
        if (do_set) begin
            r_key[tgt]   <= i_key;
            r_value[tgt] <= i_write_value;
        end
    end

endmodule

### hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache: stream ports, capacity register, pipeline registers.
//
// Usage:
//   Requests enter on the slave stream: tuser carries the kind (set, get,
//   exists, nop), tdata carries key, write value and default value. Each request
//   gives one result on the master stream: tdata carries the read value,
//   tuser carries the hit and evicted flags.
//   The capacity register is written through its own valid/ready channel,
//   which is always ready; write it only while no request is in flight.
//   A request transfers into the input register, and its result is offered
//   once the result register has loaded it. Throughput: one request per
//   cycle while the receiver does not stall; the lookup, victim choice and
//   rank update over all entries are combinational between the registers.
//   Reset empties the store, clears all ranks and sets capacity to sixteen.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; after that tready drops until
//   the result transfers.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Capacity write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_W-1:0]       i_cfg_data,
    // Request stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: key, write_value, default_value (lowest bits first), zero padded
    input  logic [((KEY_WIDTH + 2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    // tuser: kind
    input  logic [1:0]             i_s_tuser,
    // Result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: read_value, zero padded
    output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] o_m_tdata,
    // tuser: hit, evicted (lowest bit first)
    output logic [1:0]             o_m_tuser
);

    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;

    logic [CAP_W-1:0]       r_capacity;
    logic                   r_in_valid;
    t_kind                  r_in_kind;
    logic [KEY_WIDTH-1:0]   r_in_key;
    logic [VALUE_WIDTH-1:0] r_in_wval;
    logic [VALUE_WIDTH-1:0] r_in_dval;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    t_flags                 r_out_flags;

    logic                   go;
    t_flags                 flags;
    logic [VALUE_WIDTH-1:0] read_value;

    // Process the held request when the result register is free or draining
    assign go          = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || go;
    assign o_cfg_ready = 1'b1;

    // Hold the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // Capture a request on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind <= t_kind'(i_s_tuser);
            r_in_key  <= i_s_tdata[KEY_WIDTH-1:0];
            r_in_wval <= i_s_tdata[KEY_WIDTH +: VALUE_WIDTH];
            r_in_dval <= i_s_tdata[KEY_WIDTH + VALUE_WIDTH +: VALUE_WIDTH];
        end
    end

    lkvc_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (go),
        .i_kind          (r_in_kind),
        .i_key           (r_in_key),
        .i_write_value   (r_in_wval),
        .i_default_value (r_in_dval),
        .i_capacity      (r_capacity),
        .o_flags         (flags),
        .o_read_value    (read_value)
    );

    // Advance the result register; hold it while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_value <= read_value;
            r_out_flags <= flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_value);
    assign o_m_tuser  = {r_out_flags.evicted, r_out_flags.hit};

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the LRU key-value cache: directed, random and backpressure tests.
module testbench;
    import lkvc_pkg::*;

    localparam int SLOTS       = DEF_MAX_ENTRIES;
    localparam int CYCLE_LIMIT = 400000;

    // One result as the block should deliver it
    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
    } t_lookup_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [4:0]   i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // tdata: key, write_value, default_value (lowest bits first)
    logic [95:0]  i_s_tdata;
    // tuser: kind
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // tdata: read_value
    logic [31:0]  o_m_tdata;
    // tuser: hit, evicted (lowest bit first)
    logic [1:0]   o_m_tuser;

    // Shadow copy of the store, its recency order and the capacity register
    logic [31:0]  slot_key   [SLOTS];
    logic [31:0]  slot_value [SLOTS];
    logic         slot_used  [SLOTS];
    int           slot_age   [SLOTS];
    int           slots_filled;
    logic [4:0]   capacity_reg;

    t_lookup_result pending_results[$];

    int  error_count     = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  hits_seen       = 0;
    int  evictions_seen  = 0;
    int  cycle_count     = 0;
    bit  src_idling      = 1'b1;
    bit  sink_idling     = 1'b1;
    int  long_hold_cycles = 0;

    lru_key_value_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // Clock: period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at result %0d: %s got 0x%08h expected 0x%08h",
                 results_checked, what, got, want);
    endtask

    task automatic reset_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_used[i]  = 1'b0;
            slot_age[i]   = 0;
        end
        slots_filled = 0;
        capacity_reg = CAP_RESET;
    endtask

    // Age every used slot younger than limit, then make slot s the most recent
    function automatic void touch_slot(input int s, input int limit);
        for (int i = 0; i < SLOTS; i++)
            if (i != s && slot_used[i] && slot_age[i] < limit)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    // Apply one request to the shadow store and return the result it should give
    function automatic t_lookup_result apply_request(input t_kind kind, input logic [31:0] key,
                                                     input logic [31:0] wval,
                                                     input logic [31:0] dval);
        t_lookup_result r;
        int slot;
        int eff_cap;
        int oldest;
        r = '0;
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && slot_used[i] && slot_key[i] == key)
                slot = i;
        eff_cap = (capacity_reg == 0) ? 1 : (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
        case (kind)
            KIND_SET: begin
                r.hit = (slot >= 0);
                if (slot >= 0) begin
                    slot_value[slot] = wval;
                    touch_slot(slot, slot_age[slot]);
                end else begin
                    if (slots_filled >= eff_cap) begin
                        // evict the oldest used slot, ties go to the higher index
                        oldest = 0;
                        for (int i = 0; i < SLOTS; i++)
                            if (slot_used[i] && (slot < 0 || slot_age[i] >= oldest)) begin
                                oldest = slot_age[i];
                                slot = i;
                            end
                        r.evicted = 1'b1;
                        slot_used[slot] = 1'b0;
                    end else begin
                        for (int i = 0; i < SLOTS; i++)
                            if (slot < 0 && !slot_used[i])
                                slot = i;
                        slots_filled++;
                    end
                    touch_slot(slot, SLOTS + 1);
                    slot_key[slot]   = key;
                    slot_value[slot] = wval;
                    slot_used[slot]  = 1'b1;
                end
            end
            KIND_GET: begin
                r.hit = (slot >= 0);
                if (slot >= 0) begin
                    r.read_value = slot_value[slot];
                    touch_slot(slot, slot_age[slot]);
                end else begin
                    r.read_value = dval;
                end
            end
            KIND_EXISTS: r.hit = (slot >= 0);
            default: ;
        endcase
        return r;
    endfunction

    // Offer one request, after a random gap when src_idling is set, and record its expected result on transfer
    task automatic send_request(input t_kind kind, input logic [31:0] key,
                                input logic [31:0] wval, input logic [31:0] dval);
        int gap;
        gap = src_idling ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {dval, wval, key};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(apply_request(kind, key, wval, dval));
        requests_sent++;
    endtask

    // Drain every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        capacity_reg = cap;
    endtask

    // Result sink: random stall after a transfer while sink_idling is set, or a long hold on request
    initial begin : result_sink
        int hold;
        hold = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles != 0) begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end else if (hold == 0 && o_m_tvalid && i_m_tready && sink_idling) begin
                hold = $urandom_range(0, 10);
            end
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_lookup_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, read_value", o_m_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser[0] !== want.hit)
                    report_mismatch("hit", 32'(o_m_tuser[0]), 32'(want.hit));
                if (o_m_tuser[1] !== want.evicted)
                    report_mismatch("evicted", 32'(o_m_tuser[1]), 32'(want.evicted));
                if (o_m_tdata !== want.read_value)
                    report_mismatch("read_value", o_m_tdata, want.read_value);
                hits_seen      += want.hit;
                evictions_seen += want.evicted;
            end
            results_checked++;
        end
    end

    // Extremes of every field, each kind, overwrite and miss default
    task automatic test_basic_ops();
        send_request(KIND_EXISTS, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_GET,    32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
        send_request(KIND_SET,    32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(KIND_SET,    32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(KIND_GET,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_SET,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(KIND_GET,    32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(KIND_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_EXISTS, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_GET,    32'h1234_5678, 32'h0000_0000, 32'h7FFF_FFFF);
    endtask

    // Eviction order, capacity zero, capacity lowered below the fill, capacity above maximum
    task automatic test_capacity_edges();
        write_capacity(5'd2);
        send_request(KIND_GET,    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_request(KIND_SET,    32'hA5A5_A5A5, 32'h1111_1111, 32'h0000_0000);
        send_request(KIND_EXISTS, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        write_capacity(5'd0);
        send_request(KIND_SET,    32'h5A5A_5A5A, 32'h2222_2222, 32'h0000_0000);
        send_request(KIND_SET,    32'h5A5A_5A5A, 32'h3333_3333, 32'h0000_0000);
        send_request(KIND_GET,    32'hA5A5_A5A5, 32'h0000_0000, 32'h4444_4444);
        write_capacity(5'd31);
        send_request(KIND_SET,    32'h0000_0001, 32'h5555_5555, 32'h0000_0000);
        send_request(KIND_EXISTS, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    endtask

    // Random requests over a small key set, so hits and evictions are frequent
    task automatic run_random_phase(input logic [4:0] cap, input int count, input bit idling);
        logic [31:0] key_pool[$];
        int          pool_size;
        int          pick;
        t_kind       kind;
        logic [31:0] key;
        write_capacity(cap);
        src_idling  = idling;
        sink_idling = idling;
        pool_size = ((cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : int'(cap)) + $urandom_range(0, 6);
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back($urandom());
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 45) ? KIND_SET : (pick < 80) ? KIND_GET :
                   (pick < 96) ? KIND_EXISTS : KIND_NOP;
            key = ($urandom_range(0, 9) == 0) ? $urandom() :
                  key_pool[$urandom_range(0, pool_size - 1)];
            send_request(kind, key, $urandom(), $urandom());
        end
    endtask

    task automatic test_random_mix();
        run_random_phase(5'd16, 150, 1'b1);
        run_random_phase(5'd1,  130, 1'b1);
        run_random_phase(5'd31, 150, 1'b0);
        run_random_phase(5'd2,  130, 1'b1);
        run_random_phase(5'd0,  100, 1'b1);
        run_random_phase(5'd7,  150, 1'b1);
        run_random_phase(5'($urandom_range(0, 31)), 150, 1'b0);
        run_random_phase(5'd16, 150, 1'b1);
        run_random_phase(5'd3,  120, 1'b1);
        run_random_phase(5'($urandom_range(0, 31)), 150, 1'b1);
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        write_capacity(5'd4);
        src_idling  = 1'b0;
        sink_idling = 1'b1;
        long_hold_cycles = 60;
        for (int n = 0; n < 60; n++)
            send_request(t_kind'($urandom_range(0, 2)), 32'($urandom_range(0, 7)),
                         $urandom(), $urandom());
        src_idling = 1'b1;
        long_hold_cycles = 40;
        for (int n = 0; n < 40; n++)
            send_request(t_kind'($urandom_range(0, 3)), 32'($urandom_range(0, 7)),
                         $urandom(), $urandom());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        reset_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_capacity_edges();
        test_random_mix();
        test_backpressure();
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests and %0d results: %0d hits, %0d evictions,",
                 requests_sent, results_checked, hits_seen, evictions_seen);
        $display("capacities 0 through 31 with random stalls and a long output hold");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
